### hdl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Needs nothing else; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PBMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PBMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/pbmc_pkg.sv
// Package of the polygon border mesh corner block: widths, pipeline depths
// and small helper functions. Depends on nothing.
package pbmc_pkg;

  localparam int COORD_W        = 32;
  localparam int DIFF_W         = COORD_W + 1;
  localparam int THICK_W        = 31;
  localparam int IDX_W          = 10;
  localparam int CNT_W          = 11;
  localparam int TRI_W          = 12;
  localparam int UNIT_W         = 16;
  localparam int MAX_CORNERS    = 1024;
  localparam int RESULTS_PER_ITEM = 4;
  localparam int THICK_RESET    = 65536;
  localparam int UNIT_ONE       = 16384;

  // Stage counts of the unit vector pipeline.
  localparam int SQRT_STEPS     = 32;
  localparam int DIV_STEPS      = 15;
  localparam int UNIT_LAT       = SQRT_STEPS + DIV_STEPS + 5;
  localparam int IDX_STEPS      = IDX_W;

  // Clamp a wide signed sum to the signed 32-bit range.
  function automatic logic [COORD_W-1:0] sat32(input logic signed [34:0] v);
    logic [COORD_W-1:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -35'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  // Magnitude of a signed Q3.14 value of up to two units.
  function automatic logic [UNIT_W-1:0] mag17(input logic signed [UNIT_W:0] v);
    logic [UNIT_W:0] a;
    a = v[UNIT_W] ? 17'(-v) : 17'(v);
    return a[UNIT_W-1:0];
  endfunction

endpackage

### hdl/polygon_border_mesh_corner_top.sv
// Top level of the polygon border mesh corner block.
// Uses pbmc_pkg and pbmc_unit (two instances, one per edge direction).
//
//  channel   | handshake              | content
//  ----------+------------------------+-----------------------------------------
//  request   | start / busy           | prev, cur, next corner, index, count
//  result    | valid_o strobe         | vertex x/y, triangle indices, last flag
//  config    | APB psel/penable/pwrite| thickness at byte address 0
//
// A request is taken at a rising edge with start high and busy low. Each
// request yields four results on consecutive cycles, so busy stays high
// after an accepted request while the gap counter counts down, and no new
// request is taken until busy drops. The delay to the first result of a
// request is set by the 32 square root stages and 15 divider stages of
// the unit vector pipelines. The receiver cannot stall, and no pipeline
// stage ever holds. Reset clears all valid bits and sets the thickness
// to 65536.
module polygon_border_mesh_corner_top import pbmc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] prev_x_i,
  input  logic signed [COORD_W-1:0] prev_y_i,
  input  logic signed [COORD_W-1:0] cur_x_i,
  input  logic signed [COORD_W-1:0] cur_y_i,
  input  logic signed [COORD_W-1:0] next_x_i,
  input  logic signed [COORD_W-1:0] next_y_i,
  input  logic [IDX_W-1:0]          corner_index_i,
  input  logic [CNT_W-1:0]          corner_count_i,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic                      valid_o,
  output logic signed [COORD_W-1:0] vertex_x_o,
  output logic signed [COORD_W-1:0] vertex_y_o,
  output logic [TRI_W-1:0]          tri_first_o,
  output logic [TRI_W-1:0]          tri_second_o,
  output logic [TRI_W-1:0]          tri_third_o,
  output logic                      last_of_corner_o
);

  localparam int L = UNIT_LAT;

  // Configuration register.
  logic [THICK_W-1:0] thick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thick_q <= THICK_W'(THICK_RESET);
    end else if (psel && penable && pwrite && !paddr[2]) begin
      thick_q <= pwdata[THICK_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : 32'(thick_q);

  // Request acceptance: a gap counter spaces requests out so that the
  // single result port is never oversubscribed.
  logic [1:0] gap_q;
  logic       accept;

  assign accept = start && !busy;
  assign busy   = (gap_q != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= '0;
    end else if (accept) begin
      gap_q <= 2'(RESULTS_PER_ITEM - 1);
    end else if (gap_q != 2'd0) begin
      gap_q <= gap_q - 2'd1;
    end
  end

  // Input stage: edge differences, clamped corner count.
  logic                     in_vld_q;
  logic signed [DIFF_W-1:0] in_dnx_q, in_dny_q, in_dpx_q, in_dpy_q;
  logic [CNT_W-1:0]         cnt_clamp;

  always_comb begin
    if (corner_count_i == '0) begin
      cnt_clamp = CNT_W'(1);
    end else if (32'(corner_count_i) > MAX_CORNERS) begin
      cnt_clamp = CNT_W'(MAX_CORNERS);
    end else begin
      cnt_clamp = corner_count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
    end
  end

  // Side data travels in a delay line beside the unit vector pipelines. The
  // corner index is reduced modulo the count in its first stages, one
  // quotient bit per stage.
  logic signed [COORD_W-1:0] dl_cx_q  [0:L];
  logic signed [COORD_W-1:0] dl_cy_q  [0:L];
  logic [IDX_W-1:0]          dl_rem_q [0:L];
  logic [CNT_W-1:0]          dl_n_q   [0:L];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_dnx_q    <= DIFF_W'(cur_x_i) - DIFF_W'(next_x_i);
      in_dny_q    <= DIFF_W'(cur_y_i) - DIFF_W'(next_y_i);
      in_dpx_q    <= DIFF_W'(cur_x_i) - DIFF_W'(prev_x_i);
      in_dpy_q    <= DIFF_W'(cur_y_i) - DIFF_W'(prev_y_i);
      dl_cx_q[0]  <= cur_x_i;
      dl_cy_q[0]  <= cur_y_i;
      dl_rem_q[0] <= corner_index_i;
      dl_n_q[0]   <= cnt_clamp;
    end
  end

  for (genvar j = 0; j < L; j++) begin : g_delay
    if (j < IDX_STEPS) begin : g_mod
      localparam int SH = IDX_STEPS - 1 - j;
      logic [CNT_W+IDX_W-1:0] nd;
      assign nd = (CNT_W+IDX_W)'(dl_n_q[j]) << SH;
      always_ff @(posedge clk_i) begin
        if ((CNT_W+IDX_W)'(dl_rem_q[j]) >= nd) begin
          dl_rem_q[j+1] <= dl_rem_q[j] - nd[IDX_W-1:0];
        end else begin
          dl_rem_q[j+1] <= dl_rem_q[j];
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk_i) begin
        dl_rem_q[j+1] <= dl_rem_q[j];
      end
    end
    always_ff @(posedge clk_i) begin
      dl_cx_q[j+1] <= dl_cx_q[j];
      dl_cy_q[j+1] <= dl_cy_q[j];
      dl_n_q[j+1]  <= dl_n_q[j];
    end
  end

  // Unit vectors from next to current and from previous to current.
  logic                     un_vld, up_vld;
  logic signed [UNIT_W-1:0] fn_x, fn_y, fp_x, fp_y;

  pbmc_unit u_unit_next (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_vld_q),
    .dx_i        (in_dnx_q),
    .dy_i        (in_dny_q),
    .out_valid_o (un_vld),
    .ux_o        (fn_x),
    .uy_o        (fn_y)
  );

  pbmc_unit u_unit_prev (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_vld_q),
    .dx_i        (in_dpx_q),
    .dy_i        (in_dpy_q),
    .out_valid_o (up_vld),
    .ux_o        (fp_x),
    .uy_o        (fp_y)
  );

  // Multiply stage: offset magnitudes for vertices 1 to 3, and the base and
  // wrapped triangle indices.
  logic signed [UNIT_W:0] ox [1:3];
  logic signed [UNIT_W:0] oy [1:3];
  logic [TRI_W:0]         b13, tot13, w4s, w5s;

  always_comb begin
    ox[1] = 17'(fn_x);
    oy[1] = 17'(fn_y);
    ox[2] = 17'(fn_x) + 17'(fp_x);
    oy[2] = 17'(fn_y) + 17'(fp_y);
    ox[3] = 17'(fp_x);
    oy[3] = 17'(fp_y);
    b13   = {1'b0, dl_rem_q[L], 2'b00};
    tot13 = {dl_n_q[L], 2'b00};
    w4s   = b13 + 13'd4;
    w5s   = b13 + 13'd5;
    if (w4s >= tot13) begin
      w4s = w4s - tot13;
    end
    if (w5s >= tot13) begin
      w5s = w5s - tot13;
    end
  end

  logic                      m_vld_q;
  logic [46:0]               m_magx_q [1:3];
  logic [46:0]               m_magy_q [1:3];
  logic                      m_sgnx_q [1:3];
  logic                      m_sgny_q [1:3];
  logic signed [COORD_W-1:0] m_cx_q, m_cy_q;
  logic [TRI_W-1:0]          m_b_q, m_w4_q, m_w5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= un_vld && up_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 1; k <= 3; k++) begin
      m_magx_q[k] <= 47'(mag17(ox[k])) * 47'(thick_q);
      m_magy_q[k] <= 47'(mag17(oy[k])) * 47'(thick_q);
      m_sgnx_q[k] <= ox[k][UNIT_W];
      m_sgny_q[k] <= oy[k][UNIT_W];
    end
    m_cx_q <= dl_cx_q[L];
    m_cy_q <= dl_cy_q[L];
    m_b_q  <= b13[TRI_W-1:0];
    m_w4_q <= w4s[TRI_W-1:0];
    m_w5_q <= w5s[TRI_W-1:0];
  end

  // Round and add stage: round half away from zero, add to the corner and
  // saturate. The four vertices land in a small bank read by the emitter.
  logic [33:0]        offx [1:3];
  logic [33:0]        offy [1:3];
  logic signed [34:0] sumx [1:3];
  logic signed [34:0] sumy [1:3];

  always_comb begin
    for (int k = 1; k <= 3; k++) begin
      offx[k] = 34'((48'(m_magx_q[k]) + 48'(8192)) >> 14);
      offy[k] = 34'((48'(m_magy_q[k]) + 48'(8192)) >> 14);
      sumx[k] = m_sgnx_q[k] ? 35'(m_cx_q) - $signed({1'b0, offx[k]})
                            : 35'(m_cx_q) + $signed({1'b0, offx[k]});
      sumy[k] = m_sgny_q[k] ? 35'(m_cy_q) - $signed({1'b0, offy[k]})
                            : 35'(m_cy_q) + $signed({1'b0, offy[k]});
    end
  end

  logic             r_vld_q;
  logic [COORD_W-1:0] r_vx_q [0:3];
  logic [COORD_W-1:0] r_vy_q [0:3];
  logic [TRI_W-1:0] r_b_q, r_w4_q, r_w5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q <= 1'b0;
    end else begin
      r_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_vld_q) begin
      r_vx_q[0] <= m_cx_q;
      r_vy_q[0] <= m_cy_q;
      for (int k = 1; k <= 3; k++) begin
        r_vx_q[k] <= sat32(sumx[k]);
        r_vy_q[k] <= sat32(sumy[k]);
      end
      r_b_q  <= m_b_q;
      r_w4_q <= m_w4_q;
      r_w5_q <= m_w5_q;
    end
  end

  // Emitter: the first result leaves straight from the fresh bank, the other
  // three follow on the next cycles. The next bank load comes no sooner than
  // the edge that sends the fourth result, so nothing is overwritten early.
  logic             e_act_q;
  logic [1:0]       e_cnt_q;
  logic [1:0]       sel;
  logic [TRI_W-1:0] t0, t1, t2;

  assign sel = r_vld_q ? 2'd0 : e_cnt_q;

  always_comb begin
    case (sel)
      2'd0: begin
        t0 = r_b_q;
        t1 = r_b_q + 12'd1;
        t2 = r_b_q + 12'd2;
      end
      2'd1: begin
        t0 = r_b_q;
        t1 = r_b_q + 12'd2;
        t2 = r_b_q + 12'd3;
      end
      2'd2: begin
        t0 = r_b_q;
        t1 = r_b_q + 12'd3;
        t2 = r_w4_q;
      end
      default: begin
        t0 = r_b_q + 12'd3;
        t1 = r_w5_q;
        t2 = r_w4_q;
      end
    endcase
  end

  logic                      valid_q, last_q;
  logic signed [COORD_W-1:0] vx_q, vy_q;
  logic [TRI_W-1:0]          t0_q, t1_q, t2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_act_q <= 1'b0;
      e_cnt_q <= '0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else if (r_vld_q) begin
      e_act_q <= 1'b1;
      e_cnt_q <= 2'd1;
      valid_q <= 1'b1;
      last_q  <= 1'b0;
    end else if (e_act_q) begin
      e_act_q <= (e_cnt_q != 2'd3);
      e_cnt_q <= e_cnt_q + 2'd1;
      valid_q <= 1'b1;
      last_q  <= (e_cnt_q == 2'd3);
    end else begin
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_vld_q || e_act_q) begin
      vx_q <= r_vx_q[sel];
      vy_q <= r_vy_q[sel];
      t0_q <= t0;
      t1_q <= t1;
      t2_q <= t2;
    end
  end

  assign valid_o          = valid_q;
  assign last_of_corner_o = last_q;
  assign vertex_x_o       = vx_q;
  assign vertex_y_o       = vy_q;
  assign tri_first_o      = t0_q;
  assign tri_second_o     = t1_q;
  assign tri_third_o      = t2_q;

endmodule

### hdl/pbmc_unit.sv
// Pipelined unit vector of a 33-bit difference vector, Q2.14 result.
// Uses pbmc_pkg; square, bitwise square root and restoring division stages.
module pbmc_unit import pbmc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic signed [DIFF_W-1:0] dx_i,
  input  logic signed [DIFF_W-1:0] dy_i,
  output logic                     out_valid_o,
  output logic signed [UNIT_W-1:0] ux_o,
  output logic signed [UNIT_W-1:0] uy_o
);

  typedef struct packed {
    logic [30:0] ax;
    logic [30:0] ay;
    logic        sx;
    logic        sy;
    logic        zero;
  } meta_t;

  logic [UNIT_LAT-1:0] vld_q;

  logic [DIFF_W-1:0] adx, ady;
  logic              shr;
  meta_t             a_meta_d, a_meta_q, b_meta_q;
  logic [61:0]       b_sqx_q, b_sqy_q;

  meta_t       sq_meta_q [0:SQRT_STEPS];
  logic [62:0] sq_v_q    [0:SQRT_STEPS];
  logic [62:0] sq_r_q    [0:SQRT_STEPS];

  meta_t       dv_meta_q [0:DIV_STEPS];
  logic [45:0] dv_remx_q [0:DIV_STEPS];
  logic [45:0] dv_remy_q [0:DIV_STEPS];
  logic [14:0] dv_qx_q   [0:DIV_STEPS];
  logic [14:0] dv_qy_q   [0:DIV_STEPS];
  logic [31:0] dv_den_q  [0:DIV_STEPS];

  logic [31:0] len, den;
  logic [14:0] qcx, qcy;
  logic signed [UNIT_W-1:0] ux_q, uy_q;

  // Absolute values; one right shift brings both below 2^31.
  always_comb begin
    adx = dx_i[DIFF_W-1] ? DIFF_W'(-dx_i) : DIFF_W'(dx_i);
    ady = dy_i[DIFF_W-1] ? DIFF_W'(-dy_i) : DIFF_W'(dy_i);
    shr = adx[32] | adx[31] | ady[32] | ady[31];
    a_meta_d.ax   = shr ? adx[31:1] : adx[30:0];
    a_meta_d.ay   = shr ? ady[31:1] : ady[30:0];
    a_meta_d.sx   = dx_i[DIFF_W-1];
    a_meta_d.sy   = dy_i[DIFF_W-1];
    a_meta_d.zero = (adx == '0) && (ady == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[UNIT_LAT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    a_meta_q     <= a_meta_d;
    b_meta_q     <= a_meta_q;
    b_sqx_q      <= 62'(a_meta_q.ax) * 62'(a_meta_q.ax);
    b_sqy_q      <= 62'(a_meta_q.ay) * 62'(a_meta_q.ay);
    sq_meta_q[0] <= b_meta_q;
    sq_v_q[0]    <= 63'(b_sqx_q) + 63'(b_sqy_q);
    sq_r_q[0]    <= '0;
  end

  // One square root digit per stage.
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [62:0] SQ_BIT = 63'(1) << (62 - 2 * j);
    logic [62:0] trial;
    assign trial = sq_r_q[j] + SQ_BIT;
    always_ff @(posedge clk_i) begin
      sq_meta_q[j+1] <= sq_meta_q[j];
      if (sq_v_q[j] >= trial) begin
        sq_v_q[j+1] <= sq_v_q[j] - trial;
        sq_r_q[j+1] <= (sq_r_q[j] >> 1) + SQ_BIT;
      end else begin
        sq_v_q[j+1] <= sq_v_q[j];
        sq_r_q[j+1] <= sq_r_q[j] >> 1;
      end
    end
  end

  assign len = sq_r_q[SQRT_STEPS][31:0];
  assign den = (len == '0) ? 32'd1 : len;

  always_ff @(posedge clk_i) begin
    dv_meta_q[0] <= sq_meta_q[SQRT_STEPS];
    dv_remx_q[0] <= 46'({sq_meta_q[SQRT_STEPS].ax, 14'd0}) + 46'(den[31:1]);
    dv_remy_q[0] <= 46'({sq_meta_q[SQRT_STEPS].ay, 14'd0}) + 46'(den[31:1]);
    dv_qx_q[0]   <= '0;
    dv_qy_q[0]   <= '0;
    dv_den_q[0]  <= den;
  end

  // One quotient bit per stage, most significant first.
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int SH = DIV_STEPS - 1 - j;
    logic [46:0] dd;
    assign dd = 47'(dv_den_q[j]) << SH;
    always_ff @(posedge clk_i) begin
      dv_meta_q[j+1] <= dv_meta_q[j];
      dv_den_q[j+1]  <= dv_den_q[j];
      if ({1'b0, dv_remx_q[j]} >= dd) begin
        dv_remx_q[j+1] <= 46'({1'b0, dv_remx_q[j]} - dd);
        dv_qx_q[j+1]   <= dv_qx_q[j] | (15'(1) << SH);
      end else begin
        dv_remx_q[j+1] <= dv_remx_q[j];
        dv_qx_q[j+1]   <= dv_qx_q[j];
      end
      if ({1'b0, dv_remy_q[j]} >= dd) begin
        dv_remy_q[j+1] <= 46'({1'b0, dv_remy_q[j]} - dd);
        dv_qy_q[j+1]   <= dv_qy_q[j] | (15'(1) << SH);
      end else begin
        dv_remy_q[j+1] <= dv_remy_q[j];
        dv_qy_q[j+1]   <= dv_qy_q[j];
      end
    end
  end

  assign qcx = (dv_qx_q[DIV_STEPS] > 15'(UNIT_ONE)) ? 15'(UNIT_ONE) : dv_qx_q[DIV_STEPS];
  assign qcy = (dv_qy_q[DIV_STEPS] > 15'(UNIT_ONE)) ? 15'(UNIT_ONE) : dv_qy_q[DIV_STEPS];

  always_ff @(posedge clk_i) begin
    if (dv_meta_q[DIV_STEPS].zero) begin
      ux_q <= '0;
      uy_q <= '0;
    end else begin
      ux_q <= dv_meta_q[DIV_STEPS].sx ? -$signed(16'(qcx)) : $signed(16'(qcx));
      uy_q <= dv_meta_q[DIV_STEPS].sy ? -$signed(16'(qcy)) : $signed(16'(qcy));
    end
  end

  assign out_valid_o = vld_q[UNIT_LAT-1];
  assign ux_o        = ux_q;
  assign uy_o        = uy_q;

endmodule

### hdl/pbmc_checker.sv
// Port-level checker for the polygon border mesh corner top level, bound to it.
// Uses pbmc_pkg and the macros of assert_macros.svh.
`include "assert_macros.svh"

module pbmc_checker import pbmc_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic signed [COORD_W-1:0] prev_x_i,
  input logic signed [COORD_W-1:0] prev_y_i,
  input logic signed [COORD_W-1:0] cur_x_i,
  input logic signed [COORD_W-1:0] cur_y_i,
  input logic signed [COORD_W-1:0] next_x_i,
  input logic signed [COORD_W-1:0] next_y_i,
  input logic [IDX_W-1:0]          corner_index_i,
  input logic [CNT_W-1:0]          corner_count_i,
  input logic                      psel,
  input logic                      penable,
  input logic                      pwrite,
  input logic [2:0]                paddr,
  input logic [31:0]               pwdata,
  input logic [31:0]               prdata,
  input logic                      pready,
  input logic                      valid_o,
  input logic signed [COORD_W-1:0] vertex_x_o,
  input logic signed [COORD_W-1:0] vertex_y_o,
  input logic [TRI_W-1:0]          tri_first_o,
  input logic [TRI_W-1:0]          tri_second_o,
  input logic [TRI_W-1:0]          tri_third_o,
  input logic                      last_of_corner_o
);

  // An accepted request keeps the block busy after it is taken.
  `PBMC_ASSERT_NXT(a_busy_after_request, clk_i, rst_ni, start && !busy, busy ##1 busy ##1 busy, "busy did not cover a request")

  // The four results of a corner come on consecutive cycles.
  `PBMC_ASSERT_NXT(a_results_contiguous, clk_i, rst_ni, valid_o && !last_of_corner_o, valid_o, "gap inside the results of a corner")

  `PBMC_ASSERT_IMP(a_last_is_fourth, clk_i, rst_ni, valid_o && last_of_corner_o, $past(valid_o, 1) && $past(valid_o, 2) && $past(valid_o, 3), "last result without three before it")

  // The fourth triangle starts three vertices after the third one.
  `PBMC_ASSERT_IMP(a_last_tri_base, clk_i, rst_ni, valid_o && last_of_corner_o, tri_first_o == $past(tri_first_o) + 12'd3, "wrong base index on last result")

endmodule

bind polygon_border_mesh_corner_top pbmc_checker u_pbmc_checker (.*);
